### design/assert_macros.svh
// Assertion macros shared by the sequence store modules.
// Needs no other file; the asserting modules include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked property with reset disable.
`define ISS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked property that must also hold while reset is applied.
`define ISS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ISS_ASSERT(lbl, clk, rst_n, prop, msg)
`define ISS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### design/iss_pkg.sv
// Types and constants of the indexed sequence store.
// Has no dependencies; used by the controller, the datapath and the top level.
package iss_pkg;

  localparam int unsigned FUNC_W = 3;
  localparam int unsigned POS_W  = 16;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned LEN_W  = 7;

  localparam logic [FUNC_W-1:0] FN_READ   = 3'd0;
  localparam logic [FUNC_W-1:0] FN_HEAD   = 3'd1;
  localparam logic [FUNC_W-1:0] FN_TAIL   = 3'd2;
  localparam logic [FUNC_W-1:0] FN_AT     = 3'd3;
  localparam logic [FUNC_W-1:0] FN_DELETE = 3'd4;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic signed [POS_W-1:0]  position;
    logic signed [DATA_W-1:0] item_value;
  } iss_in_t;

  typedef struct packed {
    logic                     found;
    logic signed [DATA_W-1:0] read_value;
    logic [LEN_W-1:0]         length_now;
    logic                     dropped;
  } iss_out_t;

  // What the latched item turns out to be once decoded against the count.
  typedef enum logic [2:0] {
    K_NONE,
    K_READ,
    K_INSERT,
    K_DROP,
    K_DELETE
  } kind_e;

  // Write address source for the entry memory.
  typedef enum logic [2:0] {
    W_NONE,
    W_UP,
    W_UP_LAST,
    W_DN,
    W_DN_LAST,
    W_PUT
  } wsel_e;

  typedef struct packed {
    logic  load;
    logic  ptr_init;
    logic  ptr_step;
    logic  rd_ptr;
    logic  rd_slot;
    wsel_e wsel;
    logic  finish;
  } iss_cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  shift;
    logic  ptr_at_slot;
    logic  ptr_at_last;
  } iss_stat_t;

endpackage

### design/iss_ram.sv
// Generic single write port, single read port RAM with registered read data.
// Has no dependencies.
module iss_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/iss_ctrl.sv
// Controller state machine of the indexed sequence store.
// Depends on iss_pkg and assert_macros.svh; drives the datapath by commands.
`include "assert_macros.svh"
module iss_ctrl import iss_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  output logic      busy_o,
  output logic      done_o,
  input  iss_stat_t stat_i,
  output iss_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_RD_WAIT,
    ST_UP,
    ST_UP_LAST,
    ST_PUT,
    ST_DN,
    ST_DN_LAST,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   pend_q, pend_d;
  logic   busy_q, busy_d;
  logic   done_q, done_d;

  always_comb begin
    cmd_o      = '0;
    cmd_o.wsel = W_NONE;
    state_d    = state_q;
    pend_d     = pend_q;
    busy_d     = busy_q;
    done_d     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i && !busy_q) begin
          cmd_o.load = 1'b1;
          busy_d     = 1'b1;
          state_d    = ST_EVAL;
        end
      end
      ST_EVAL: begin
        pend_d = 1'b0;
        case (stat_i.kind)
          K_READ: begin
            cmd_o.rd_slot = 1'b1;
            state_d       = ST_RD_WAIT;
          end
          K_INSERT: begin
            if (stat_i.shift) begin
              cmd_o.ptr_init = 1'b1;
              state_d        = ST_UP;
            end else begin
              state_d = ST_PUT;
            end
          end
          K_DELETE: begin
            if (stat_i.shift) begin
              cmd_o.ptr_init = 1'b1;
              state_d        = ST_DN;
            end else begin
              state_d = ST_FINISH;
            end
          end
          default: begin
            state_d = ST_FINISH;
          end
        endcase
      end
      ST_RD_WAIT: begin
        state_d = ST_FINISH;
      end
      ST_UP: begin
        // Read the entry at the pointer; the one read last cycle moves up one place.
        cmd_o.rd_ptr = 1'b1;
        cmd_o.wsel   = pend_q ? W_UP : W_NONE;
        pend_d       = 1'b1;
        if (stat_i.ptr_at_slot) begin
          state_d = ST_UP_LAST;
        end else begin
          cmd_o.ptr_step = 1'b1;
        end
      end
      ST_UP_LAST: begin
        cmd_o.wsel = W_UP_LAST;
        state_d    = ST_PUT;
      end
      ST_PUT: begin
        cmd_o.wsel = W_PUT;
        state_d    = ST_FINISH;
      end
      ST_DN: begin
        cmd_o.rd_ptr = 1'b1;
        cmd_o.wsel   = pend_q ? W_DN : W_NONE;
        pend_d       = 1'b1;
        if (stat_i.ptr_at_last) begin
          state_d = ST_DN_LAST;
        end else begin
          cmd_o.ptr_step = 1'b1;
        end
      end
      ST_DN_LAST: begin
        cmd_o.wsel = W_DN_LAST;
        state_d    = ST_FINISH;
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        done_d       = 1'b1;
        busy_d       = 1'b0;
        state_d      = ST_IDLE;
      end
      default: begin
        busy_d  = 1'b0;
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pend_q  <= 1'b0;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      busy_q  <= busy_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

  `ISS_ASSERT(a_done_single, clk_i, rst_ni, done_q |=> !done_q, "result strobe held two cycles")
  `ISS_ASSERT_ALWAYS(a_done_idle, clk_i, done_q |-> !busy_q, "result strobe while busy")
  `ISS_ASSERT(a_start_busy, clk_i, rst_ni, (start_i && !busy_q) |=> (busy_q && !done_q),
              "accepted item did not raise busy")

endmodule

### design/iss_dp.sv
// Datapath of the indexed sequence store: item latch, count, pointer, entry RAM.
// Depends on iss_pkg, iss_ram and assert_macros.svh.
`include "assert_macros.svh"
module iss_dp import iss_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  iss_in_t   op_i,
  input  iss_cmd_t  cmd_i,
  output iss_stat_t stat_o,
  output iss_out_t  result_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = POS_W - 1;

  iss_in_t          op_q;
  iss_out_t         result_q, result_d;
  logic [CW-1:0]    count_q, count_d;
  logic [AW-1:0]    ptr_q, ptr_d;

  logic             pos_neg;
  logic [PW-1:0]    pos_mag;
  logic [PW-1:0]    cnt_ext;
  logic             pos_lt, pos_eq, pos_le0, full;
  kind_e            kind;
  kind_e            ins_kind;
  logic [PW-1:0]    slot_w;
  logic [AW-1:0]    slot;
  logic [AW-1:0]    cnt_last;

  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;

  // Decode of the latched item against the current count.
  assign pos_neg  = op_q.position[POS_W-1];
  assign pos_mag  = op_q.position[PW-1:0];
  assign cnt_ext  = PW'(count_q);
  assign pos_lt   = !pos_neg && (pos_mag < cnt_ext);
  assign pos_eq   = !pos_neg && (pos_mag == cnt_ext);
  assign pos_le0  = pos_neg || (pos_mag == '0);
  assign full     = (count_q >= CW'(CAPACITY));
  assign ins_kind = full ? K_DROP : K_INSERT;

  always_comb begin
    kind   = K_NONE;
    slot_w = pos_mag;
    case (op_q.func)
      FN_READ: begin
        kind = pos_lt ? K_READ : K_NONE;
      end
      FN_HEAD: begin
        kind   = ins_kind;
        slot_w = '0;
      end
      FN_TAIL: begin
        kind   = ins_kind;
        slot_w = cnt_ext;
      end
      FN_AT: begin
        if (pos_eq) begin
          kind   = ins_kind;
          slot_w = cnt_ext;
        end else if (pos_le0) begin
          kind   = ins_kind;
          slot_w = '0;
        end else if (pos_lt) begin
          kind = ins_kind;
        end
      end
      FN_DELETE: begin
        kind = pos_lt ? K_DELETE : K_NONE;
      end
      default: begin
        kind = K_NONE;
      end
    endcase
  end

  assign slot     = AW'(slot_w);
  assign cnt_last = AW'(count_q - 1'b1);

  always_comb begin
    stat_o.kind        = kind;
    stat_o.shift       = (kind == K_DELETE) ? ((slot_w + 1'b1) != cnt_ext)
                                            : (slot_w != cnt_ext);
    stat_o.ptr_at_slot = (ptr_q == slot);
    stat_o.ptr_at_last = (ptr_q == cnt_last);
  end

  // Pointer walks down from the last entry on insert, up from slot+1 on delete.
  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.ptr_init) begin
      ptr_d = (kind == K_INSERT) ? cnt_last : AW'(slot + 1'b1);
    end else if (cmd_i.ptr_step) begin
      ptr_d = (kind == K_INSERT) ? AW'(ptr_q - 1'b1) : AW'(ptr_q + 1'b1);
    end
  end

  assign ram_re    = cmd_i.rd_ptr || cmd_i.rd_slot;
  assign ram_raddr = cmd_i.rd_slot ? slot : ptr_q;
  assign ram_we    = (cmd_i.wsel != W_NONE);
  assign ram_wdata = (cmd_i.wsel == W_PUT) ? op_q.item_value : ram_rdata;

  always_comb begin
    case (cmd_i.wsel)
      W_UP:      ram_waddr = AW'(ptr_q + 1'b1 + 1'b1);
      W_UP_LAST: ram_waddr = AW'(ptr_q + 1'b1);
      W_DN:      ram_waddr = AW'(ptr_q - 1'b1 - 1'b1);
      W_DN_LAST: ram_waddr = AW'(ptr_q - 1'b1);
      W_PUT:     ram_waddr = slot;
      default:   ram_waddr = '0;
    endcase
  end

  always_comb begin
    count_d  = count_q;
    result_d = result_q;
    if (cmd_i.finish) begin
      case (kind)
        K_INSERT: count_d = CW'(count_q + 1'b1);
        K_DELETE: count_d = CW'(count_q - 1'b1);
        default:  count_d = count_q;
      endcase
      result_d.found      = (kind == K_READ);
      result_d.read_value = (kind == K_READ) ? ram_rdata : '1;
      result_d.length_now = LEN_W'(count_d);
      result_d.dropped    = (kind == K_DROP);
    end
  end

  iss_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CAPACITY)
  ) u_entries (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= op_i;
    end
    ptr_q    <= ptr_d;
    result_q <= result_d;
  end

  assign result_o = result_q;

  `ISS_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CW'(CAPACITY),
              "entry count above capacity")

endmodule

### design/indexed_sequence_store_unit.sv
// Top level of the indexed sequence store: an ordered list of signed 32-bit values.
// Depends on iss_pkg, iss_ctrl, iss_dp (which holds the iss_ram entry memory).
//
// Usage: drive op_i (func, position, item_value) and raise start. The item is
// accepted at a rising edge where start is high and busy is low. Exactly one
// result per item appears on result_o, flagged by done_o for a single cycle;
// the receiver cannot stall it, so it must take the result in that cycle.
// The strobe cycle has busy low, so the next item may be accepted at its end.
//
// Each item passes an evaluate state and a finish state; a read waits for the
// registered RAM read between them, an insert writes the new value in a put
// state, and an insert or delete that moves entries first walks them in turn.
// Busy stays high from an accept until the strobe, so items never overlap.
// The entries live in a RAM with one write port and a registered read port,
// so an insert or delete moves one entry per cycle through that port: the
// worst case is an insert at the head of a nearly full list.
// Reset clears the count and the controller; the entry RAM is not cleared,
// since only positions below the count are ever read.
module indexed_sequence_store_unit import iss_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  iss_in_t  op_i,
  output logic     done_o,
  output iss_out_t result_o
);

  // Commands from the controller and decode status back from the datapath.
  iss_cmd_t  cmd;
  iss_stat_t stat;

  iss_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .busy_o (busy),
    .done_o (done_o),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  iss_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .op_i    (op_i),
    .cmd_i   (cmd),
    .stat_o  (stat),
    .result_o(result_o)
  );

endmodule
